// ----- src/scfd_pkg.sv -----
// shared constants, codes and types for the serial command frame decoder
package scfd_pkg;

	// frame buffer size and derived widths
	localparam int MAX_FRAME  = 32;
	localparam int NUM_FIELDS = 6;
	localparam int CNT_W      = $clog2(MAX_FRAME + 1);

	// command field positions within a frame
	localparam int FLD_ID     = 0;
	localparam int FLD_TYPE   = 1;
	localparam int FLD_FUNC   = 2;
	localparam int FLD_PARAM1 = 4;
	localparam int FLD_PARAM2 = 5;

	// framing bytes
	localparam logic [7:0] BYTE_NL = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;

	// device types and ids
	localparam logic [7:0] DEV_TYPE_SENSOR = 8'h00;
	localparam logic [7:0] DEV_TYPE_ACT    = 8'h01;
	localparam logic [7:0] DEV_ID_BUZZER   = 8'h01;
	localparam logic [7:0] DEV_ID_MOTOR    = 8'h02;
	localparam logic [7:0] SENSOR_ID_MAX   = 8'h0F;

	// function codes
	localparam logic [7:0] FN_BUZZ_ON  = 8'h00;
	localparam logic [7:0] FN_BUZZ_OFF = 8'h01;
	localparam logic [7:0] FN_FWD      = 8'h00;
	localparam logic [7:0] FN_BACK     = 8'h01;
	localparam logic [7:0] FN_RIGHT    = 8'h02;
	localparam logic [7:0] FN_LEFT     = 8'h03;
	localparam logic [7:0] FN_STOP     = 8'h04;
	localparam logic [7:0] FN_SPEED    = 8'h09;

	// motor direction pin codes
	localparam logic [3:0] DIR_FWD   = 4'h6;
	localparam logic [3:0] DIR_BACK  = 4'h9;
	localparam logic [3:0] DIR_RIGHT = 4'hA;
	localparam logic [3:0] DIR_LEFT  = 4'h5;
	localparam logic [3:0] DIR_STOP  = 4'h0;

	localparam logic [7:0] DUTY_RESET = 8'hFF;

	// completed frame handed from the collector to the decoder
	typedef struct packed {
		logic       done;
		logic [7:0] dev_id;
		logic [7:0] dev_type;
		logic [7:0] func;
		logic [7:0] param1;
		logic [7:0] param2;
	} frame_t;

	// one result item
	typedef struct packed {
		logic       frame_done;
		logic [3:0] direction_code;
		logic       buzzer_active;
		logic [7:0] left_duty;
		logic [7:0] right_duty;
		logic       sensor_request;
		logic [3:0] sensor_channel;
		logic       echo_valid;
		logic [7:0] echo_byte;
	} result_t;

endpackage

// ----- src/scfd_if.sv -----
// valid/ready channel interfaces for received bytes and decoded results
interface scfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfd_res_if;
	logic       valid;
	logic       ready;
	logic       frame_done;
	logic [3:0] direction_code;
	logic       buzzer_active;
	logic [7:0] left_duty;
	logic [7:0] right_duty;
	logic       sensor_request;
	logic [3:0] sensor_channel;
	logic       echo_valid;
	logic [7:0] echo_byte;

	modport source (output valid, input ready, output frame_done, output direction_code,
		output buzzer_active, output left_duty, output right_duty, output sensor_request,
		output sensor_channel, output echo_valid, output echo_byte);
	modport sink (input valid, output ready, input frame_done, input direction_code,
		input buzzer_active, input left_duty, input right_duty, input sensor_request,
		input sensor_channel, input echo_valid, input echo_byte);
endinterface

// ----- src/scfd_collect.sv -----
// frame collector: byte buffer, count, terminator check and kept command fields
module scfd_collect (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      rx_byte,
	output scfd_pkg::frame_t frame
);
	import scfd_pkg::*;

	logic [7:0]       pend_q [NUM_FIELDS];
	logic [7:0]       cmd_q [NUM_FIELDS];
	logic [CNT_W-1:0] count_q;
	logic             armed_q;

	logic [7:0]       pend_nx [NUM_FIELDS];
	logic [7:0]       cmd_nx [NUM_FIELDS];
	logic [CNT_W-1:0] cnt_after;
	logic [CNT_W-1:0] count_nx;
	logic             armed_nx;
	logic             is_nl;
	logic             is_cr;
	logic             wr;

	// classify the byte and decide whether it goes into the buffer
	always_comb begin
		is_nl = (rx_byte == BYTE_NL);
		is_cr = armed_q && (rx_byte == BYTE_CR);
		wr    = (is_nl || is_cr || !armed_q) && (count_q < CNT_W'(MAX_FRAME));
		cnt_after = wr ? count_q + CNT_W'(1) : count_q;
		count_nx  = is_cr ? '0 : cnt_after;
		armed_nx  = is_nl ? 1'b1 : (is_cr ? 1'b0 : armed_q);
	end

	// buffer write and field copy on completion
	always_comb begin
		for (int k = 0; k < NUM_FIELDS; k++) begin
			pend_nx[k] = (wr && count_q == CNT_W'(k)) ? rx_byte : pend_q[k];
			cmd_nx[k]  = (is_cr && CNT_W'(k) < cnt_after) ? pend_nx[k] : cmd_q[k];
		end
	end

	assign frame.done     = is_cr;
	assign frame.dev_id   = cmd_nx[FLD_ID];
	assign frame.dev_type = cmd_nx[FLD_TYPE];
	assign frame.func     = cmd_nx[FLD_FUNC];
	assign frame.param1   = cmd_nx[FLD_PARAM1];
	assign frame.param2   = cmd_nx[FLD_PARAM2];

	// buffer entries hold no reset value; only entries of the current frame are read
	always_ff @(posedge clk) begin
		if (step) begin
			for (int k = 0; k < NUM_FIELDS; k++) begin
				pend_q[k] <= pend_nx[k];
			end
		end
	end

	// count, armed flag and kept fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			armed_q <= 1'b0;
			for (int k = 0; k < NUM_FIELDS; k++) begin
				cmd_q[k] <= '0;
			end
		end else if (step) begin
			count_q <= count_nx;
			armed_q <= armed_nx;
			for (int k = 0; k < NUM_FIELDS; k++) begin
				cmd_q[k] <= cmd_nx[k];
			end
		end
	end

endmodule

// ----- src/scfd_decode.sv -----
// command decoder: actuator registers and result fields
module scfd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  scfd_pkg::frame_t  frame,
	output scfd_pkg::result_t res
);
	import scfd_pkg::*;

	logic [3:0] dir_q;
	logic       buzz_q;
	logic [7:0] ldut_q;
	logic [7:0] rdut_q;

	logic [3:0] dir_nx;
	logic       buzz_nx;
	logic [7:0] ldut_nx;
	logic [7:0] rdut_nx;
	logic       req;
	logic       echo;

	// decode the completed frame
	always_comb begin
		dir_nx  = dir_q;
		buzz_nx = buzz_q;
		ldut_nx = ldut_q;
		rdut_nx = rdut_q;
		req     = 1'b0;
		echo    = 1'b0;
		if (frame.done) begin
			if (frame.dev_type == DEV_TYPE_SENSOR) begin
				req = (frame.dev_id <= SENSOR_ID_MAX);
			end else if (frame.dev_type == DEV_TYPE_ACT) begin
				if (frame.dev_id == DEV_ID_BUZZER) begin
					if (frame.func == FN_BUZZ_ON) begin
						buzz_nx = 1'b1;
					end else if (frame.func == FN_BUZZ_OFF) begin
						buzz_nx = 1'b0;
					end
				end else if (frame.dev_id == DEV_ID_MOTOR) begin
					case (frame.func)
						FN_FWD:   dir_nx = DIR_FWD;
						FN_BACK:  dir_nx = DIR_BACK;
						FN_RIGHT: dir_nx = DIR_RIGHT;
						FN_LEFT:  dir_nx = DIR_LEFT;
						FN_STOP:  dir_nx = DIR_STOP;
						FN_SPEED: begin
							dir_nx  = DIR_FWD;
							ldut_nx = frame.param1;
							rdut_nx = frame.param2;
							echo    = 1'b1;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// result fields show the state after this request
	always_comb begin
		res.frame_done     = frame.done;
		res.direction_code = dir_nx;
		res.buzzer_active  = buzz_nx;
		res.left_duty      = ldut_nx;
		res.right_duty     = rdut_nx;
		res.sensor_request = req;
		res.sensor_channel = req ? frame.dev_id[3:0] : 4'h0;
		res.echo_valid     = echo;
		res.echo_byte      = echo ? frame.param1 : 8'h00;
	end

	// actuator registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_STOP;
			buzz_q <= 1'b0;
			ldut_q <= DUTY_RESET;
			rdut_q <= DUTY_RESET;
		end else if (step) begin
			dir_q  <= dir_nx;
			buzz_q <= buzz_nx;
			ldut_q <= ldut_nx;
			rdut_q <= rdut_nx;
		end
	end

endmodule

// ----- src/serial_command_frame_decoder.sv -----
// serial command frame decoder top level: input register, decode, result register
// an accepted byte is held in the input register, then decoded into the result register
// throughput: one byte per cycle while results are taken; input and result register
// form a two-entry pipeline, so a new request is taken while a finished result waits
// reset: arst_n clears the count, armed flag, command fields, direction and buzzer,
// sets both duties to 255 and empties both pipeline stages
module serial_command_frame_decoder (
	input logic     clk,
	input logic     arst_n,
	scfd_rx_if.sink   rx,
	scfd_res_if.source res
);
	import scfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;

	logic       adv;
	frame_t     frame;
	result_t    res_nx;

	// stage two takes the item when the result register is empty or drained
	assign adv      = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || adv;

	scfd_collect u_collect (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.frame   (frame)
	);

	scfd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.frame  (frame),
		.res    (res_nx)
	);

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
		if (adv) begin
			res_s2 <= res_nx;
		end
	end

	assign res.valid          = valid_s2;
	assign res.frame_done     = res_s2.frame_done;
	assign res.direction_code = res_s2.direction_code;
	assign res.buzzer_active  = res_s2.buzzer_active;
	assign res.left_duty      = res_s2.left_duty;
	assign res.right_duty     = res_s2.right_duty;
	assign res.sensor_request = res_s2.sensor_request;
	assign res.sensor_channel = res_s2.sensor_channel;
	assign res.echo_valid     = res_s2.echo_valid;
	assign res.echo_byte      = res_s2.echo_byte;

endmodule

// ----- src/scfd_checker.sv -----
// port-level checks for the serial command frame decoder, bound to the top level
module scfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       frame_done,
	input logic [3:0] direction_code,
	input logic [7:0] left_duty,
	input logic       sensor_request,
	input logic       echo_valid,
	input logic [7:0] echo_byte
);
	import scfd_pkg::*;

	// a waiting result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// sensor requests only come from a completed frame
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sensor_request |-> frame_done)
		else $error("sensor request without completed frame");

	// echo only on a speed command: forward and left duty equal to the echo
	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && echo_valid |-> frame_done && direction_code == DIR_FWD &&
			left_duty == echo_byte)
		else $error("echo inconsistent with speed command");

	// no echo and no request at once
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(echo_valid && sensor_request))
		else $error("echo and sensor request together");

	// direction is always one of the pin codes
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> direction_code == DIR_FWD || direction_code == DIR_BACK ||
			direction_code == DIR_RIGHT || direction_code == DIR_LEFT ||
			direction_code == DIR_STOP)
		else $error("illegal direction code");

endmodule

bind serial_command_frame_decoder scfd_checker u_scfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.frame_done     (res.frame_done),
	.direction_code (res.direction_code),
	.left_duty      (res.left_duty),
	.sensor_request (res.sensor_request),
	.echo_valid     (res.echo_valid),
	.echo_byte      (res.echo_byte)
);

// ----- verif/testbench.sv -----
// self-checking testbench for the serial command frame decoder
module testbench;
	import scfd_pkg::*;

	logic clk;
	logic arst_n;

	scfd_rx_if  rx ();
	scfd_res_if res ();

	serial_command_frame_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res)
	);

	// bytes waiting to be sent and decoded results still owed by the block
	logic [7:0] byte_q [$];
	result_t    expect_q [$];

	// shadow copy of the decoder state
	logic [7:0]       held_bytes [NUM_FIELDS];
	logic [CNT_W-1:0] frame_len;
	logic             nl_seen;
	logic [7:0]       cmd_fields [NUM_FIELDS];
	logic [3:0]       motor_dir;
	logic             buzz_on;
	logic [7:0]       duty_l;
	logic [7:0]       duty_r;

	int fail_count;
	int bytes_sent;
	int results_seen;
	int frames_seen;
	int sensor_seen;
	int echo_seen;
	int full_hits;
	int rx_wait;
	int rx_idle_pct;
	int res_wait;
	int res_idle_pct;
	result_t got;
	result_t want;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// wait length for one request, sometimes forced to zero for back-to-back stretches
	function automatic int draw_wait(int pct);
		return ($urandom_range(0, 99) < pct) ? int'($urandom_range(0, 9)) : 0;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 30;
			default: return 100;
		endcase
	endfunction

	// store into the frame buffer, saturating at the buffer size
	function automatic void buffer_byte(logic [7:0] b);
		if (frame_len < MAX_FRAME) begin
			if (frame_len < NUM_FIELDS)
				held_bytes[frame_len[2:0]] = b;
			frame_len = frame_len + 1'b1;
		end else begin
			full_hits++;
		end
	endfunction

	// advance the shadow state by one byte and return the expected result
	function automatic result_t decode_byte(logic [7:0] b);
		result_t r;
		r = '0;
		if (b == BYTE_NL) begin
			buffer_byte(b);
			nl_seen = 1'b1;
		end else if (nl_seen && b == BYTE_CR) begin
			buffer_byte(b);
			for (int k = 0; k < NUM_FIELDS; k++)
				if (k < frame_len)
					cmd_fields[k] = held_bytes[k];
			frame_len = '0;
			nl_seen = 1'b0;
			r.frame_done = 1'b1;
			case (cmd_fields[FLD_TYPE])
				DEV_TYPE_SENSOR: begin
					if (cmd_fields[FLD_ID] <= SENSOR_ID_MAX) begin
						r.sensor_request = 1'b1;
						r.sensor_channel = cmd_fields[FLD_ID][3:0];
					end
				end
				DEV_TYPE_ACT: begin
					if (cmd_fields[FLD_ID] == DEV_ID_BUZZER) begin
						if (cmd_fields[FLD_FUNC] == FN_BUZZ_ON)
							buzz_on = 1'b1;
						else if (cmd_fields[FLD_FUNC] == FN_BUZZ_OFF)
							buzz_on = 1'b0;
					end else if (cmd_fields[FLD_ID] == DEV_ID_MOTOR) begin
						case (cmd_fields[FLD_FUNC])
							FN_FWD:   motor_dir = DIR_FWD;
							FN_BACK:  motor_dir = DIR_BACK;
							FN_RIGHT: motor_dir = DIR_RIGHT;
							FN_LEFT:  motor_dir = DIR_LEFT;
							FN_STOP:  motor_dir = DIR_STOP;
							FN_SPEED: begin
								motor_dir = DIR_FWD;
								duty_l = cmd_fields[FLD_PARAM1];
								duty_r = cmd_fields[FLD_PARAM2];
								r.echo_valid = 1'b1;
								r.echo_byte = cmd_fields[FLD_PARAM1];
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end else if (!nl_seen) begin
			buffer_byte(b);
		end
		r.direction_code = motor_dir;
		r.buzzer_active = buzz_on;
		r.left_duty = duty_l;
		r.right_duty = duty_r;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			fail_count++;
		end
	endfunction

	// one frame: payload, newline, optional repeats and dropped bytes, optional carriage return
	task automatic add_frame(logic [7:0] id, logic [7:0] kind, logic [7:0] fn, int len,
		bit extra_nl, bit noise, bit close);
		logic [7:0] body [NUM_FIELDS];
		logic [7:0] b;
		body[FLD_ID] = id;
		body[FLD_TYPE] = kind;
		body[FLD_FUNC] = fn;
		body[3] = 8'($urandom);
		body[FLD_PARAM1] = 8'($urandom);
		body[FLD_PARAM2] = 8'($urandom);
		for (int k = 0; k < len; k++)
			byte_q.push_back(k < NUM_FIELDS ? body[k] : 8'($urandom));
		byte_q.push_back(BYTE_NL);
		if (extra_nl)
			repeat ($urandom_range(1, 2)) byte_q.push_back(BYTE_NL);
		if (noise)
			repeat ($urandom_range(1, 3)) begin
				do b = 8'($urandom); while (b == BYTE_CR);
				byte_q.push_back(b);
			end
		if (close)
			byte_q.push_back(BYTE_CR);
	endtask

	// request driver: pulls bytes from the queue, predicts each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx.valid <= 1'b0;
			rx.rx_byte <= '0;
			rx_wait = 0;
		end else if (!rx.valid || rx.ready) begin
			if (rx.valid)
				expect_q.push_back(decode_byte(rx.rx_byte));
			if (rx_wait > 0) begin
				rx.valid <= 1'b0;
				rx_wait--;
			end else if (byte_q.size() > 0) begin
				if (bytes_sent % 100 == 0)
					rx_idle_pct = pick_pct();
				rx.valid <= 1'b1;
				rx.rx_byte <= byte_q.pop_front();
				bytes_sent++;
				rx_wait = draw_wait(rx_idle_pct);
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// result monitor: random back-pressure, compares against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			res_wait = 0;
		end else if (res.valid && res.ready) begin
			got.frame_done = res.frame_done;
			got.direction_code = res.direction_code;
			got.buzzer_active = res.buzzer_active;
			got.left_duty = res.left_duty;
			got.right_duty = res.right_duty;
			got.sensor_request = res.sensor_request;
			got.sensor_channel = res.sensor_channel;
			got.echo_valid = res.echo_valid;
			got.echo_byte = res.echo_byte;
			if (expect_q.size() == 0) begin
				$error("result arrived with no request outstanding");
				fail_count++;
			end else begin
				want = expect_q.pop_front();
				check_field("frame_done", want.frame_done, got.frame_done);
				check_field("direction_code", want.direction_code, got.direction_code);
				check_field("buzzer_active", want.buzzer_active, got.buzzer_active);
				check_field("left_duty", want.left_duty, got.left_duty);
				check_field("right_duty", want.right_duty, got.right_duty);
				check_field("sensor_request", want.sensor_request, got.sensor_request);
				check_field("sensor_channel", want.sensor_channel, got.sensor_channel);
				check_field("echo_valid", want.echo_valid, got.echo_valid);
				check_field("echo_byte", want.echo_byte, got.echo_byte);
				frames_seen += want.frame_done;
				sensor_seen += want.sensor_request;
				echo_seen += want.echo_valid;
			end
			if (results_seen % 100 == 0)
				res_idle_pct = pick_pct();
			results_seen++;
			res_wait = draw_wait(res_idle_pct);
			res.ready <= (res_wait == 0);
		end else if (!res.ready) begin
			if (res_wait <= 1) begin
				res_wait = 0;
				res.ready <= 1'b1;
			end else begin
				res_wait--;
			end
		end
	end

	// watchdog
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// stimulus and end of run
	initial begin
		logic [7:0] directed [];
		logic [7:0] motor_fns [6];
		logic [7:0] id;
		logic [7:0] kind;
		logic [7:0] fn;
		int len;
		int pick;
		int idx;

		rx.valid = 1'b0;
		rx.rx_byte = '0;
		res.ready = 1'b0;
		arst_n = 1'b0;

		fail_count = 0;
		bytes_sent = 0;
		results_seen = 0;
		frames_seen = 0;
		sensor_seen = 0;
		echo_seen = 0;
		full_hits = 0;
		rx_idle_pct = 0;
		res_idle_pct = 0;

		// shadow state after reset
		foreach (held_bytes[k]) held_bytes[k] = '0;
		foreach (cmd_fields[k]) cmd_fields[k] = '0;
		frame_len = '0;
		nl_seen = 1'b0;
		motor_dir = DIR_STOP;
		buzz_on = 1'b0;
		duty_l = DUTY_RESET;
		duty_r = DUTY_RESET;

		// directed: top sensor channel, buzzer on, speed with duty extremes,
		// repeated newline with a dropped byte and an out-of-range sensor id,
		// then a carriage return seen before any newline and an unknown type
		directed = '{
			8'h0F, DEV_TYPE_SENSOR, BYTE_NL, BYTE_CR,
			DEV_ID_BUZZER, DEV_TYPE_ACT, FN_BUZZ_ON, BYTE_NL, BYTE_CR,
			DEV_ID_MOTOR, DEV_TYPE_ACT, FN_SPEED, 8'h00, 8'h00, 8'hFF, BYTE_NL, BYTE_CR,
			8'h10, DEV_TYPE_SENSOR, BYTE_NL, BYTE_NL, 8'hFF, BYTE_CR,
			BYTE_CR, BYTE_NL, BYTE_CR
		};
		foreach (directed[k]) byte_q.push_back(directed[k]);

		// random: mostly well-formed frames with random content, some noise and broken frames
		motor_fns = '{FN_FWD, FN_BACK, FN_RIGHT, FN_LEFT, FN_STOP, FN_SPEED};
		while (byte_q.size() < directed.size() + 1100) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 6)) byte_q.push_back(8'($urandom));
			end else begin
				fn = 8'($urandom);
				case ($urandom_range(0, 4))
					0: begin
						kind = DEV_TYPE_SENSOR;
						id = ($urandom_range(0, 3) == 0) ? 8'($urandom)
							: 8'($urandom_range(0, 15));
					end
					1: begin
						kind = DEV_TYPE_ACT;
						id = DEV_ID_BUZZER;
						fn = 8'($urandom_range(0, 2));
					end
					2, 3: begin
						kind = DEV_TYPE_ACT;
						id = DEV_ID_MOTOR;
						idx = $urandom_range(0, 7);
						if (idx < 6)
							fn = motor_fns[idx];
						else if (idx == 6)
							fn = FN_SPEED;
					end
					default: begin
						kind = 8'($urandom_range(0, 2));
						id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
						if ($urandom_range(0, 3) == 0)
							kind = 8'($urandom);
					end
				endcase
				pick = $urandom_range(0, 99);
				if (pick < 4)
					len = $urandom_range(MAX_FRAME - 4, MAX_FRAME + 8);
				else if (pick < 20)
					len = $urandom_range(0, 5);
				else
					len = $urandom_range(6, 9);
				add_frame(id, kind, fn, len, $urandom_range(0, 4) == 0,
					$urandom_range(0, 4) == 0, $urandom_range(0, 19) != 0);
			end
		end

		// reset once
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all requests taken, all results back, then spare idle cycles
		while (byte_q.size() != 0 || rx.valid) @(negedge clk);
		while (expect_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);

		$display("checked %0d results for %0d bytes: %0d frames, %0d sensor requests, %0d echoes",
			results_seen, bytes_sent, frames_seen, sensor_seen, echo_seen);
		$display("bytes past a full buffer: %0d", full_hits);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
